FILE: src/fpa_mac_pkg.sv
// shared constants and arithmetic helpers for the fixed-point mac unit
package fpa_mac_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int FRAC_W = 5;

   localparam logic [FRAC_W-1:0] FRAC_MIN   = FRAC_W'(1);
   localparam logic [FRAC_W-1:0] FRAC_MAX   = FRAC_W'(16);
   localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

   // clamp the programmed fraction width into its legal range
   function automatic logic [FRAC_W-1:0] eff_frac(input logic [FRAC_W-1:0] f);
      logic [FRAC_W-1:0] r;
      begin
         if (f < FRAC_MIN) begin
            r = FRAC_MIN;
         end else if (f > FRAC_MAX) begin
            r = FRAC_MAX;
         end else begin
            r = f;
         end
         return r;
      end
   endfunction

   // saturate to the signed range of 2n bits
   function automatic logic signed [DATA_W-1:0] sat_range(
      input logic signed [PROD_W-1:0] x,
      input logic [FRAC_W-1:0]        n
   );
      logic [FRAC_W:0]           sh;
      logic signed [PROD_W-1:0]  hi;
      logic signed [PROD_W-1:0]  lo;
      logic signed [DATA_W-1:0]  r;
      begin
         sh = {n, 1'b0} - (FRAC_W+1)'(1);
         hi = (PROD_W'(1) <<< sh) - PROD_W'(1);
         lo = -hi - PROD_W'(1);
         if (x > hi) begin
            r = hi[DATA_W-1:0];
         end else if (x < lo) begin
            r = lo[DATA_W-1:0];
         end else begin
            r = x[DATA_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

FILE: src/fixed_point_affine_dot_mac_unit.sv
// top level: saturating fixed-point multiply-accumulate with bias on the last item
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_a_value, req_b_value, req_bias, req_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_result
//  csr     | in        | csr_wr_en           | csr_wr_data (frac_bits)
//
// one item is taken per cycle while req_stall is low; the 32x32 multiplier, then
// the shift/saturate and accumulator loop, then the bias add and saturate each own
// one register stage; a finished sum moves to the bias stage, then to rsp_result.
// reset clears the accumulator and all valid bits and sets frac_bits to 16.
// stages with a bubble downstream keep moving while rsp is stalled; req stalls only
// when the product stage holds a last item that cannot move on.
module fixed_point_affine_dot_mac_unit
   import fpa_mac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_a_value,
   input  logic signed [DATA_W-1:0] req_b_value,
   input  logic signed [DATA_W-1:0] req_bias,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   input  logic                     csr_wr_en,
   input  logic [FRAC_W-1:0]        csr_wr_data
);

   logic [FRAC_W-1:0]        frac_ff;
   logic [FRAC_W-1:0]        frac_eff;

   // product stage
   logic                     s1_v_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic signed [PROD_W-1:0] s1_prod_in;
   logic signed [DATA_W-1:0] s1_bias_ff;
   logic                     s1_last_ff;

   // accumulate stage
   logic signed [DATA_W-1:0] acc_ff;
   logic signed [DATA_W-1:0] acc_sum;
   logic signed [DATA_W-1:0] sat_prod;
   logic signed [PROD_W-1:0] shifted;

   // bias stage
   logic                     s2_v_ff;
   logic signed [DATA_W-1:0] s2_acc_ff;
   logic signed [DATA_W-1:0] s2_bias_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_result_ff;
   logic signed [DATA_W-1:0] rsp_result_in;

   logic                     out_free;
   logic                     s2_free;
   logic                     s1_consume;
   logic                     s1_free;
   logic                     req_take;

   assign frac_eff   = eff_frac(frac_ff);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_free    = !s2_v_ff || out_free;
   assign s1_consume = s1_v_ff && (!s1_last_ff || s2_free);
   assign s1_free    = !s1_v_ff || s1_consume;
   assign req_stall  = !s1_free;
   assign req_take   = req_valid && s1_free;

   assign s1_prod_in = PROD_W'(req_a_value) * PROD_W'(req_b_value);

   assign shifted    = s1_prod_ff >>> frac_eff;
   assign sat_prod   = sat_range(shifted, frac_eff);
   assign acc_sum    = acc_ff + sat_prod;

   assign rsp_result_in = sat_range(PROD_W'(s2_acc_ff) + PROD_W'(s2_bias_ff), frac_eff);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff      <= FRAC_RESET;
         s1_v_ff      <= 1'b0;
         acc_ff       <= '0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frac_ff <= csr_wr_data;
         end
         if (s1_free) begin
            s1_v_ff <= req_valid;
         end
         if (s1_consume) begin
            acc_ff <= s1_last_ff ? '0 : acc_sum;
         end
         if (s1_consume && s1_last_ff) begin
            s2_v_ff <= 1'b1;
         end else if (out_free) begin
            s2_v_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_prod_ff <= s1_prod_in;
         s1_bias_ff <= req_bias;
         s1_last_ff <= req_last;
      end
      if (s1_consume && s1_last_ff) begin
         s2_acc_ff  <= acc_sum;
         s2_bias_ff <= s1_bias_ff;
      end
      if (s2_v_ff && out_free) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      s1_consume && s1_last_ff |=> acc_ff == '0)
      else $error("accumulator not cleared after last item");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_v_ff && s1_last_ff && s2_v_ff)
      else $error("input stalled without a blocked last item");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_consume |=> s1_v_ff && $stable(s1_prod_ff) && $stable(acc_ff))
      else $error("product stage lost or changed a waiting item");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_free |=> s2_v_ff && $stable(s2_acc_ff))
      else $error("bias stage dropped an item while output stalled");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      frac_eff >= FRAC_MIN && frac_eff <= FRAC_MAX)
      else $error("effective fraction width out of range");

endmodule
